>>> rtl/assert_macros.svh
// assertion macros used by the checker file bhpq_chk.sv
// no dependencies; the including module must have clk and arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while reset is asserted
`define BHPQ_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bhpq assertion failed");

// next-cycle implication, sampled on clk, off while reset is asserted
`define BHPQ_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bhpq assertion failed");

`endif

>>> rtl/bhpq_pkg.sv
// shared types, sizes and codes for the binary heap priority queue
// no dependencies
package bhpq_pkg;

	// heap size and derived widths
	localparam int HEAP_DEPTH = 128;
	localparam int ADDR_W     = $clog2(HEAP_DEPTH);
	localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
	localparam int CHILD_W    = ADDR_W + 2;

	// field widths
	localparam int KEY_W      = 32;
	localparam int TAG_W      = 8;
	localparam int ENTRY_W    = KEY_W + TAG_W;
	localparam int COUNT_W    = 8;
	localparam int STATUS_W   = 2;

	// stream word widths, padded to whole bytes
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 56;

	// output word bit positions
	localparam int O_KEY_LO   = 0;
	localparam int O_TAG_LO   = O_KEY_LO + KEY_W;
	localparam int O_CNT_LO   = O_TAG_LO + TAG_W;
	localparam int O_EMPTY    = O_CNT_LO + COUNT_W;
	localparam int O_STAT_LO  = O_EMPTY + 1;
	localparam int O_USED_W   = O_STAT_LO + STATUS_W;

	// command codes
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BAD   = 2'd3;

	// one stored heap entry
	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [TAG_W-1:0]        tag;
	} entry_t;

	// operands for the shared key comparator
	typedef struct packed {
		logic signed [KEY_W-1:0] a_key;
		logic signed [KEY_W-1:0] b_key;
		logic                    min_first;
	} cmp_req_t;

endpackage

>>> rtl/binary_heap_priority_queue_core.sv
// binary heap priority queue top level: sequencer, count and output register
// depends on bhpq_pkg, bhpq_ram, bhpq_cmp
//
// channel  direction  handshake                 contents
// s_*      in         s_tvalid / s_tready       tuser: cmd; tdata: new_key, new_tag
// m_*      out        m_tvalid / m_tready       tdata: top_key, top_tag, count, empty, status
// cfg_*    in         cfg_valid / cfg_ready     order_mode
//
// one word in flight; a push climbs level by level until its parent does not yield or
// it reaches the root; a pop moves the last entry to the root and sinks it level by
// level, with no descent when it takes the last entry; a full or empty reject only reads
// the root; each level is one dual-port memory read, the shared comparator and one write
// the result register lets the next word in; its result then waits in the last state
// reset clears count, order mode and control; the heap memory needs no clearing
module binary_heap_priority_queue_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [bhpq_pkg::IN_DATA_W-1:0]     s_tdata,   // new_key, new_tag
	input  logic                               s_tuser,   // cmd
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// top_key, top_tag, entry_count, heap_empty, status, pad
	output logic [bhpq_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic                               cfg_data   // order_mode
);

	localparam int ADDR_W  = bhpq_pkg::ADDR_W;
	localparam int CNT_W   = bhpq_pkg::CNT_W;
	localparam int CHILD_W = bhpq_pkg::CHILD_W;

	// sequencer states
	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_UP_CHK  = 4'd1;
	localparam logic [3:0] S_UP_CMP  = 4'd2;
	localparam logic [3:0] S_DN_LOAD = 4'd3;
	localparam logic [3:0] S_DN_RD   = 4'd4;
	localparam logic [3:0] S_DN_CMPL = 4'd5;
	localparam logic [3:0] S_DN_CMPR = 4'd6;
	localparam logic [3:0] S_ROOT_RD = 4'd7;
	localparam logic [3:0] S_FINISH  = 4'd8;

	logic [3:0]                      state_q;
	logic [CNT_W-1:0]                count_q;
	logic                            order_q;
	logic [bhpq_pkg::STATUS_W-1:0]   status_q;
	logic [ADDR_W-1:0]               node_q;
	bhpq_pkg::entry_t                mov_q;
	bhpq_pkg::entry_t                best_q;
	logic                            best_self_q;
	logic [ADDR_W-1:0]               best_idx_q;
	logic                            out_valid_q;
	logic [bhpq_pkg::OUT_DATA_W-1:0] out_q;

	logic                            in_acc;
	logic                            out_free;
	bhpq_pkg::entry_t                in_entry;
	bhpq_pkg::entry_t                top_e;

	// memory port signals
	logic                            ram_we;
	logic [ADDR_W-1:0]               ram_waddr;
	bhpq_pkg::entry_t                ram_wdata;
	logic                            ram_re_a;
	logic [ADDR_W-1:0]               ram_raddr_a;
	logic                            ram_re_b;
	logic [ADDR_W-1:0]               ram_raddr_b;
	logic [bhpq_pkg::ENTRY_W-1:0]    ram_rdata_a;
	logic [bhpq_pkg::ENTRY_W-1:0]    ram_rdata_b;
	bhpq_pkg::entry_t                rd_a;
	bhpq_pkg::entry_t                rd_b;

	// comparator
	bhpq_pkg::cmp_req_t              cmp_req;
	logic                            cmp_yields;

	// tree index arithmetic
	logic [ADDR_W-1:0]               parent_idx;
	logic [CHILD_W-1:0]              left_idx;
	logic [CHILD_W-1:0]              right_idx;
	logic                            left_ok;
	logic                            right_ok;

	assign in_acc    = s_tvalid && s_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || m_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_q;

	assign in_entry.key = s_tdata[bhpq_pkg::KEY_W-1:0];
	assign in_entry.tag = s_tdata[bhpq_pkg::ENTRY_W-1:bhpq_pkg::KEY_W];

	assign rd_a = ram_rdata_a;
	assign rd_b = ram_rdata_b;

	// root entry for the result, zero when the heap is empty
	assign top_e = (count_q != '0) ? rd_a : '0;

	assign parent_idx = (node_q - ADDR_W'(1)) >> 1;
	assign left_idx   = (CHILD_W'(node_q) << 1) + CHILD_W'(1);
	assign right_idx  = (CHILD_W'(node_q) << 1) + CHILD_W'(2);
	assign left_ok    = left_idx < CHILD_W'(count_q);
	assign right_ok   = right_idx < CHILD_W'(count_q);

	// heap storage
	bhpq_ram #(
		.WIDTH (bhpq_pkg::ENTRY_W),
		.DEPTH (bhpq_pkg::HEAP_DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.re_a    (ram_re_a),
		.raddr_a (ram_raddr_a),
		.rdata_a (ram_rdata_a),
		.re_b    (ram_re_b),
		.raddr_b (ram_raddr_b),
		.rdata_b (ram_rdata_b)
	);

	bhpq_cmp u_cmp (
		.req    (cmp_req),
		.yields (cmp_yields)
	);

	// comparator operand select
	always_comb begin
		cmp_req.min_first = order_q;
		cmp_req.a_key     = mov_q.key;
		cmp_req.b_key     = mov_q.key;
		unique case (state_q)
			S_UP_CMP: begin
				cmp_req.a_key = rd_a.key;
				cmp_req.b_key = mov_q.key;
			end
			S_DN_CMPL: begin
				cmp_req.a_key = mov_q.key;
				cmp_req.b_key = rd_a.key;
			end
			S_DN_CMPR: begin
				cmp_req.a_key = best_q.key;
				cmp_req.b_key = rd_b.key;
			end
			default: begin
				cmp_req.a_key = mov_q.key;
				cmp_req.b_key = mov_q.key;
			end
		endcase
	end

	// memory access per state
	always_comb begin
		ram_we      = 1'b0;
		ram_waddr   = node_q;
		ram_wdata   = mov_q;
		ram_re_a    = 1'b0;
		ram_raddr_a = '0;
		ram_re_b    = 1'b0;
		ram_raddr_b = '0;
		unique case (state_q)
			S_IDLE: begin
				// fetch the last entry for a pop
				if (in_acc && s_tuser == bhpq_pkg::CMD_POP && count_q != '0) begin
					ram_re_a    = 1'b1;
					ram_raddr_a = ADDR_W'(count_q - CNT_W'(1));
				end
			end
			S_UP_CHK: begin
				if (node_q == '0) begin
					ram_we    = 1'b1;
					ram_waddr = '0;
					ram_wdata = mov_q;
				end else begin
					ram_re_a    = 1'b1;
					ram_raddr_a = parent_idx;
				end
			end
			S_UP_CMP: begin
				ram_we    = 1'b1;
				ram_waddr = node_q;
				ram_wdata = cmp_yields ? rd_a : mov_q;
			end
			S_DN_RD: begin
				ram_re_a    = 1'b1;
				ram_raddr_a = left_idx[ADDR_W-1:0];
				ram_re_b    = 1'b1;
				ram_raddr_b = right_idx[ADDR_W-1:0];
			end
			S_DN_CMPR: begin
				ram_we    = 1'b1;
				ram_waddr = node_q;
				if (right_ok && cmp_yields) begin
					ram_wdata = rd_b;
				end else if (best_self_q) begin
					ram_wdata = mov_q;
				end else begin
					ram_wdata = best_q;
				end
			end
			S_ROOT_RD: begin
				ram_re_a    = 1'b1;
				ram_raddr_a = '0;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// order mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			order_q <= cfg_data;
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			status_q <= bhpq_pkg::ST_OK;
			node_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						status_q <= bhpq_pkg::ST_OK;
						if (s_tuser == bhpq_pkg::CMD_PUSH) begin
							if (count_q == CNT_W'(bhpq_pkg::HEAP_DEPTH)) begin
								status_q <= bhpq_pkg::ST_FULL;
								state_q  <= S_ROOT_RD;
							end else begin
								node_q  <= count_q[ADDR_W-1:0];
								count_q <= count_q + CNT_W'(1);
								state_q <= S_UP_CHK;
							end
						end else begin
							if (count_q == '0) begin
								status_q <= bhpq_pkg::ST_EMPTY;
								state_q  <= S_ROOT_RD;
							end else begin
								count_q <= count_q - CNT_W'(1);
								state_q <= S_DN_LOAD;
							end
						end
					end
				end
				S_UP_CHK: begin
					state_q <= (node_q == '0) ? S_ROOT_RD : S_UP_CMP;
				end
				S_UP_CMP: begin
					if (cmp_yields) begin
						node_q  <= parent_idx;
						state_q <= S_UP_CHK;
					end else begin
						state_q <= S_ROOT_RD;
					end
				end
				S_DN_LOAD: begin
					node_q  <= '0;
					state_q <= (count_q == '0) ? S_ROOT_RD : S_DN_RD;
				end
				S_DN_RD: begin
					state_q <= S_DN_CMPL;
				end
				S_DN_CMPL: begin
					state_q <= S_DN_CMPR;
				end
				S_DN_CMPR: begin
					if (right_ok && cmp_yields) begin
						node_q  <= right_idx[ADDR_W-1:0];
						state_q <= S_DN_RD;
					end else if (best_self_q) begin
						state_q <= S_ROOT_RD;
					end else begin
						node_q  <= best_idx_q;
						state_q <= S_DN_RD;
					end
				end
				S_ROOT_RD: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// moving entry and best-child payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_acc) begin
			mov_q <= in_entry;
		end
		if (state_q == S_DN_LOAD) begin
			mov_q <= rd_a;
		end
		if (state_q == S_DN_CMPL) begin
			if (left_ok && cmp_yields) begin
				best_q      <= rd_a;
				best_self_q <= 1'b0;
				best_idx_q  <= left_idx[ADDR_W-1:0];
			end else begin
				best_q      <= mov_q;
				best_self_q <= 1'b1;
				best_idx_q  <= node_q;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result word: key, tag, count, empty flag, status from the low bit up
	always_ff @(posedge clk) begin
		if (state_q == S_FINISH && out_free) begin
			out_q <= bhpq_pkg::OUT_DATA_W'({status_q, (count_q == '0),
				bhpq_pkg::COUNT_W'(count_q), top_e.tag, top_e.key});
		end
	end

endmodule

>>> rtl/bhpq_ram.sv
// generic single-write, dual-read memory with registered read data
// no dependencies
module bhpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic                     re_b,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read ports, data held until the next read
	always_ff @(posedge clk) begin
		if (re_a) begin
			rdata_a <= mem_q[raddr_a];
		end
		if (re_b) begin
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

>>> rtl/bhpq_cmp.sv
// shared key comparator: does entry a yield to entry b under the order mode
// depends on bhpq_pkg
module bhpq_cmp (
	input  bhpq_pkg::cmp_req_t req,
	output logic               yields
);

	// strict compare, equal keys never yield
	always_comb begin
		if (req.min_first) begin
			yields = req.a_key > req.b_key;
		end else begin
			yields = req.a_key < req.b_key;
		end
	end

endmodule

>>> rtl/bhpq_chk.sv
// port-level checker for the binary heap priority queue, bound to the top level
// depends on bhpq_pkg, assert_macros.svh, binary_heap_priority_queue_core
`include "assert_macros.svh"

module bhpq_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [bhpq_pkg::OUT_DATA_W-1:0] m_tdata
);

	logic [bhpq_pkg::COUNT_W-1:0]  o_cnt;
	logic                          o_empty;
	logic [bhpq_pkg::STATUS_W-1:0] o_stat;
	logic [bhpq_pkg::KEY_W-1:0]    o_key;
	logic [bhpq_pkg::TAG_W-1:0]    o_tag;

	// unpack the result word
	assign o_key   = m_tdata[bhpq_pkg::O_TAG_LO-1:bhpq_pkg::O_KEY_LO];
	assign o_tag   = m_tdata[bhpq_pkg::O_CNT_LO-1:bhpq_pkg::O_TAG_LO];
	assign o_cnt   = m_tdata[bhpq_pkg::O_EMPTY-1:bhpq_pkg::O_CNT_LO];
	assign o_empty = m_tdata[bhpq_pkg::O_EMPTY];
	assign o_stat  = m_tdata[bhpq_pkg::O_USED_W-1:bhpq_pkg::O_STAT_LO];

	// a stalled result word holds
	`BHPQ_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// empty flag agrees with the count
	`BHPQ_ASSERT_IMP(a_empty_cnt, m_tvalid, o_empty == (o_cnt == '0))

	// an empty heap reports a zero top
	`BHPQ_ASSERT_IMP(a_empty_top, m_tvalid && o_empty, o_key == '0 && o_tag == '0)

	// status is never the unused code
	`BHPQ_ASSERT_IMP(a_stat_code, m_tvalid, o_stat != bhpq_pkg::ST_BAD)

	// one word at a time: busy right after taking a word
	`BHPQ_ASSERT_NXT(a_busy, s_tvalid && s_tready, !s_tready)

endmodule

bind binary_heap_priority_queue_core bhpq_chk u_bhpq_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> verif/tb.sv
// self-checking testbench for binary_heap_priority_queue_core: a heap tracker class
// mirrors the queue and checks every result word; tasks drive push/pop and order words
// depends on bhpq_pkg and the rtl of binary_heap_priority_queue_core
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 1_500_000;
	localparam int          MAX_REPORTS = 10;
	localparam int          DRAIN_WAIT  = 40;
	localparam int          PRESSURE_AT = 300;
	localparam int          PRESSURE_LEN = 600;
	localparam logic signed [bhpq_pkg::KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;
	localparam logic signed [bhpq_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

	// what the block reports after one word
	typedef struct packed {
		logic signed [bhpq_pkg::KEY_W-1:0] key;
		logic [bhpq_pkg::TAG_W-1:0]        tag;
		logic [bhpq_pkg::COUNT_W-1:0]      count;
		logic                              empty;
		logic [bhpq_pkg::STATUS_W-1:0]     status;
	} heap_report_t;

	// mirror of the heap: applies each accepted word and holds the reports still due
	class heap_tracker;
		bhpq_pkg::entry_t slots[bhpq_pkg::HEAP_DEPTH];
		int unsigned      fill;
		bit               min_first;
		heap_report_t     due_reports[$];
		int               fails;
		int               results_seen;

		function new();
			fill = 0;
			min_first = 1'b0;
			fails = 0;
			results_seen = 0;
		endfunction

		function void set_order(bit v);
			min_first = v;
		endfunction

		function int pending();
			return due_reports.size();
		endfunction

		// a ranks below b under the current order; equal keys never move
		function bit ranks_below(logic signed [bhpq_pkg::KEY_W-1:0] a,
				logic signed [bhpq_pkg::KEY_W-1:0] b);
			return min_first ? (a > b) : (a < b);
		endfunction

		function void swap_slots(int unsigned x, int unsigned y);
			bhpq_pkg::entry_t tmp;
			tmp = slots[x];
			slots[x] = slots[y];
			slots[y] = tmp;
		endfunction

		function void climb(int unsigned n);
			int unsigned up;
			while (n > 0) begin
				up = (n - 1) / 2;
				if (!ranks_below(slots[up].key, slots[n].key))
					break;
				swap_slots(up, n);
				n = up;
			end
		endfunction

		function void sink(int unsigned n);
			int unsigned best;
			int unsigned lc;
			int unsigned rc;
			while (n < fill) begin
				best = n;
				lc = 2 * n + 1;
				rc = 2 * n + 2;
				if (lc < fill && ranks_below(slots[best].key, slots[lc].key))
					best = lc;
				if (rc < fill && ranks_below(slots[best].key, slots[rc].key))
					best = rc;
				if (best == n)
					break;
				swap_slots(n, best);
				n = best;
			end
		endfunction

		// apply one accepted word and queue the report it should produce
		function void note_item(logic cmd, logic signed [bhpq_pkg::KEY_W-1:0] key,
				logic [bhpq_pkg::TAG_W-1:0] tag);
			heap_report_t rep;
			rep.status = bhpq_pkg::ST_OK;
			if (cmd == bhpq_pkg::CMD_PUSH) begin
				if (fill >= bhpq_pkg::HEAP_DEPTH) begin
					rep.status = bhpq_pkg::ST_FULL;
				end else begin
					slots[fill].key = key;
					slots[fill].tag = tag;
					fill++;
					climb(fill - 1);
				end
			end else begin
				if (fill == 0) begin
					rep.status = bhpq_pkg::ST_EMPTY;
				end else begin
					fill--;
					slots[0] = slots[fill];
					sink(0);
				end
			end
			rep.key   = (fill > 0) ? slots[0].key : '0;
			rep.tag   = (fill > 0) ? slots[0].tag : '0;
			rep.count = fill[bhpq_pkg::COUNT_W-1:0];
			rep.empty = (fill == 0);
			due_reports.push_back(rep);
		endfunction

		function void flag(string msg);
			fails++;
			if (fails <= MAX_REPORTS)
				$display("[%0t] %s", $time, msg);
		endfunction

		// compare one result word with the oldest report due
		function void check_word(logic [bhpq_pkg::OUT_DATA_W-1:0] w);
			heap_report_t want;
			heap_report_t got;
			got.key    = w[bhpq_pkg::O_KEY_LO +: bhpq_pkg::KEY_W];
			got.tag    = w[bhpq_pkg::O_TAG_LO +: bhpq_pkg::TAG_W];
			got.count  = w[bhpq_pkg::O_CNT_LO +: bhpq_pkg::COUNT_W];
			got.empty  = w[bhpq_pkg::O_EMPTY];
			got.status = w[bhpq_pkg::O_STAT_LO +: bhpq_pkg::STATUS_W];
			results_seen++;
			if (due_reports.size() == 0) begin
				flag($sformatf("result %0d with nothing due: %h", results_seen, w));
				return;
			end
			want = due_reports.pop_front();
			if (got.key !== want.key || got.tag !== want.tag || got.count !== want.count ||
					got.empty !== want.empty || got.status !== want.status)
				flag($sformatf({"result %0d mismatch: expected key %0d tag %0d count %0d ",
					"empty %0b status %0d, got key %0d tag %0d count %0d empty %0b status %0d"},
					results_seen, want.key, want.tag, want.count, want.empty, want.status,
					got.key, got.tag, got.count, got.empty, got.status));
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [bhpq_pkg::IN_DATA_W-1:0]  s_tdata = '0;    // new_key, new_tag
	logic                            s_tuser = bhpq_pkg::CMD_PUSH;  // cmd
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	// top_key, top_tag, entry_count, heap_empty, status, pad
	logic [bhpq_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic                            cfg_data = 1'b0;

	heap_tracker tracker = new();
	int          items_sent = 0;
	bit          quiet = 1'b0;
	int unsigned cycle_count = 0;

	binary_heap_priority_queue_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// clock, 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// sender gap: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(15, 60);
	endfunction

	// keys: extremes, a narrow band full of ties, and full-width values
	function automatic logic signed [bhpq_pkg::KEY_W-1:0] draw_key();
		case ($urandom_range(0, 9))
			0: return KEY_MIN;
			1: return KEY_MAX;
			2, 3, 4: return $urandom_range(0, 16) - 8;
			default: return $urandom();
		endcase
	endfunction

	// random payload byte
	function automatic logic [bhpq_pkg::TAG_W-1:0] draw_tag();
		return bhpq_pkg::TAG_W'($urandom_range(0, 255));
	endfunction

	// offer one word and wait for it to be taken
	task automatic send_item(input logic cmd, input logic signed [bhpq_pkg::KEY_W-1:0] key,
			input logic [bhpq_pkg::TAG_W-1:0] tag);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {tag, key};
		do @(posedge clk); while (!s_tready);
		tracker.note_item(cmd, key, tag);
		items_sent++;
	endtask

	task automatic pop_item();
		send_item(bhpq_pkg::CMD_POP, draw_key(), draw_tag());
	endtask

	// order word, written only once every result is back
	task automatic write_order(input bit v);
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_order(v);
		cfg_valid <= 1'b0;
	endtask

	// result side: checks, random stalls and one long hold-off
	initial begin : rx
		int run_left;
		bit run_ready;
		int hold_left;
		bit held;
		run_left = 0;
		run_ready = 1'b1;
		hold_left = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				tracker.check_word(m_tdata);
			if (!held && items_sent >= PRESSURE_AT) begin
				held = 1'b1;
				hold_left = PRESSURE_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (quiet) begin
				m_tready <= 1'b1;
			end else begin
				if (run_left == 0) begin
					run_ready = ($urandom_range(0, 3) != 0);
					run_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 4)
						: $urandom_range(10, 80);
				end
				run_left--;
				m_tready <= run_ready;
			end
		end
	end

	// stimulus
	initial begin : stim
		bit phase_mode[10] = '{0, 1, 1, 1, 0, 0, 1, 0, 1, 0};
		int phase_push[10] = '{92, 50, 10, 92, 50, 10, 55, 92, 10, 50};
		int phase_len[10]  = '{220, 150, 200, 220, 150, 200, 150, 220, 200, 150};
		bit phase_quiet[10] = '{0, 0, 0, 0, 0, 0, 1, 0, 0, 1};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// largest first: empty pop, lone entry, extremes, ties
		write_order(1'b0);
		pop_item();
		send_item(bhpq_pkg::CMD_PUSH, KEY_MIN, 8'd0);
		pop_item();
		send_item(bhpq_pkg::CMD_PUSH, KEY_MAX, 8'd255);
		send_item(bhpq_pkg::CMD_PUSH, KEY_MIN, 8'd1);
		send_item(bhpq_pkg::CMD_PUSH, 32'sd0, 8'd2);
		send_item(bhpq_pkg::CMD_PUSH, -32'sd1, 8'd3);
		send_item(bhpq_pkg::CMD_PUSH, 32'sd5, 8'd4);
		send_item(bhpq_pkg::CMD_PUSH, 32'sd5, 8'd5);
		send_item(bhpq_pkg::CMD_PUSH, 32'sd5, 8'd6);
		repeat (8) pop_item();

		// smallest first
		write_order(1'b1);
		send_item(bhpq_pkg::CMD_PUSH, KEY_MAX, 8'd170);
		send_item(bhpq_pkg::CMD_PUSH, KEY_MIN, 8'd85);
		send_item(bhpq_pkg::CMD_PUSH, 32'sd0, 8'd255);
		repeat (4) pop_item();

		// random phases: fill to full, drain to empty, mixed; order flips with entries held
		for (int p = 0; p < 10; p++) begin
			write_order(phase_mode[p]);
			quiet = phase_quiet[p];
			for (int i = 0; i < phase_len[p]; i++) begin
				if ($urandom_range(0, 99) < phase_push[p])
					send_item(bhpq_pkg::CMD_PUSH, draw_key(), draw_tag());
				else
					pop_item();
			end
		end

		// drain and settle
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (tracker.fails == 0 && tracker.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
